// ----- rtl/smpv_pkg.sv -----
// ----------------------------------------------------------------------------
// smpv_pkg
// Shared types, constants and SHA-256 helper functions for the salted Merkle
// proof verifier.
// ----------------------------------------------------------------------------
package smpv_pkg;

  localparam int unsigned NumRootWords = 4;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned CountW       = 6;

  localparam logic [CfgIdxW-1:0] CFG_ROOT_0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROOT_1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROOT_2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROOT_3 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SALT   = 3'd4;

  typedef struct packed {
    logic [63:0] node_word_0;
    logic [63:0] node_word_1;
    logic [63:0] node_word_2;
    logic [63:0] node_word_3;
    logic        node_is_left;
    logic        last_node;
  } node_item_t;

  typedef struct packed {
    logic                proof_passed;
    logic [CountW-1:0]   nodes_in_proof;
  } result_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_WAIT,
    ST_RESULT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the accepted item
    logic start;  // start a three-block hash of the held pair
    logic finish; // update count and, on the last node, the result
  } dp_cmd_t;

  typedef struct packed {
    logic needs_hash; // accepted item requires a hash
    logic hash_done;
    logic last;
  } dp_status_t;

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] k_round(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
  endfunction

  // 64 hex characters of a 256-bit digest, first character most significant.
  function automatic logic [511:0] hex_digest(input logic [255:0] d);
    logic [511:0] r;
    for (int i = 0; i < 64; i++) begin
      r[511-8*i -: 8] = hex_char(d[255-4*i -: 4]);
    end
    return r;
  endfunction

endpackage

// ----- rtl/smpv_if.sv -----
// ----------------------------------------------------------------------------
// smpv_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface smpv_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/smpv_sha_core.sv -----
// ----------------------------------------------------------------------------
// smpv_sha_core
// SHA-256 compression of one 512-bit block, one round per cycle, with a
// sixteen-word rolling message schedule.
// ----------------------------------------------------------------------------
module smpv_sha_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [255:0] state_i,
  input  logic [511:0] block_i,
  output logic         done_o,
  output logic [255:0] state_o
);
  import smpv_pkg::*;

  logic [31:0]  w_q [16];
  logic [31:0]  w_d [16];
  logic [255:0] v_q, v_d, base_q;
  logic [5:0]   rnd_q;
  logic         busy_q, done_q;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, wn;

  always_comb begin
    {a, b, c, d, e, f, g, h} = v_q;
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + k_round(rnd_q) + w_q[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    v_d = {t1 + t2, a, b, c, d + t1, e, f, g};
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
    for (int i = 0; i < 15; i++) begin
      w_d[i] = w_q[i+1];
    end
    w_d[15] = wn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= state_i;
      base_q <= state_i;
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= block_i[511-32*i -: 32];
      end
    end else if (busy_q) begin
      v_q <= v_d;
      w_q <= w_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      state_o[255-32*i -: 32] = base_q[255-32*i -: 32] + v_q[255-32*i -: 32];
    end
  end

  assign done_o = done_q;

endmodule

// ----- rtl/smpv_datapath.sv -----
// ----------------------------------------------------------------------------
// smpv_datapath
// Node registers, message assembly over three blocks, running digest, node
// count and root comparison.
// ----------------------------------------------------------------------------
module smpv_datapath #(
  parameter int unsigned MaxProofNodes = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smpv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [smpv_pkg::CfgDataW-1:0] cfg_data_i,
  input  smpv_pkg::node_item_t          item_i,
  input  smpv_pkg::dp_cmd_t             cmd_i,
  output smpv_pkg::dp_status_t          status_o,
  output smpv_pkg::result_item_t        result_o
);
  import smpv_pkg::*;

  localparam int unsigned SeenW = $clog2(MaxProofNodes + 1);

  logic [255:0] root_q, running_q, first_q, node_q, left_q, right_q;
  logic [63:0]  salt_q;
  logic         last_q, one_node_q;
  logic [SeenW-1:0] seen_q;
  logic [1:0]   blk_q, blk_sel;
  logic         core_start, core_done, hashing_q;
  logic [255:0] core_state;
  logic [1023:0] msg_hex;
  logic [511:0] blk;
  result_item_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      salt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROOT_0: root_q[255:192] <= cfg_data_i;
        CFG_ROOT_1: root_q[191:128] <= cfg_data_i;
        CFG_ROOT_2: root_q[127:64]  <= cfg_data_i;
        CFG_ROOT_3: root_q[63:0]    <= cfg_data_i;
        CFG_SALT:   salt_q          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign msg_hex = {hex_digest(left_q), hex_digest(right_q)};

  // The block handed to the core is the one that starts at this edge.
  assign blk_sel = cmd_i.start ? 2'd0 : blk_q + 2'd1;

  always_comb begin
    unique case (blk_sel)
      2'd0:    blk = msg_hex[1023:512];
      2'd1:    blk = msg_hex[511:0];
      default: blk = {salt_q, 8'h80, 376'd0, 64'd1088};
    endcase
  end

  assign core_start = cmd_i.start || (hashing_q && core_done && blk_q != 2'd2);

  smpv_sha_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .state_i (cmd_i.start ? H_INIT : core_state),
    .block_i (blk),
    .done_o  (core_done),
    .state_o (core_state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      hashing_q <= 1'b0;
      blk_q     <= '0;
      running_q <= '0;
    end else begin
      if (cmd_i.start) begin
        hashing_q <= 1'b1;
        blk_q     <= 2'd0;
      end else if (hashing_q && core_done) begin
        if (blk_q == 2'd2) begin
          hashing_q <= 1'b0;
          running_q <= core_state;
        end
        blk_q <= blk_q + 2'd1;
      end
      if (cmd_i.finish) begin
        seen_q <= last_q ? '0
                : (seen_q < SeenW'(MaxProofNodes)) ? seen_q + 1'b1 : seen_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      node_q     <= {item_i.node_word_0, item_i.node_word_1,
                     item_i.node_word_2, item_i.node_word_3};
      last_q     <= item_i.last_node;
      one_node_q <= (seen_q == '0);
      if (seen_q == '0) begin
        first_q <= {item_i.node_word_0, item_i.node_word_1,
                    item_i.node_word_2, item_i.node_word_3};
      end else if (seen_q == SeenW'(1)) begin
        left_q  <= first_q;
        right_q <= {item_i.node_word_0, item_i.node_word_1,
                    item_i.node_word_2, item_i.node_word_3};
      end else if (item_i.node_is_left) begin
        left_q  <= {item_i.node_word_0, item_i.node_word_1,
                    item_i.node_word_2, item_i.node_word_3};
        right_q <= running_q;
      end else begin
        left_q  <= running_q;
        right_q <= {item_i.node_word_0, item_i.node_word_1,
                    item_i.node_word_2, item_i.node_word_3};
      end
    end
    if (cmd_i.finish && last_q) begin
      res_q.proof_passed   <= one_node_q ? (node_q == root_q) : (running_q == root_q);
      res_q.nodes_in_proof <= CountW'((seen_q < SeenW'(MaxProofNodes))
                                      ? seen_q + 1'b1 : seen_q);
    end
  end

  assign status_o.needs_hash = ~one_node_q;
  assign status_o.hash_done  = hashing_q && core_done && (blk_q == 2'd2);
  assign status_o.last       = last_q;
  assign result_o            = res_q;

endmodule

// ----- rtl/smpv_ctrl.sv -----
// ----------------------------------------------------------------------------
// smpv_ctrl
// Controller: accepts a node, sequences the hash and hands out the result.
// ----------------------------------------------------------------------------
module smpv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  smpv_pkg::dp_status_t status_i,
  output smpv_pkg::dp_cmd_t    cmd_o
);
  import smpv_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_HASH;
        end
      end
      ST_HASH: begin
        if (status_i.needs_hash) begin
          cmd_o.start = 1'b1;
          state_d     = ST_WAIT;
        end else if (status_i.last) begin
          state_d = ST_RESULT;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (status_i.hash_done) begin
          if (status_i.last) begin
            state_d = ST_RESULT;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/salted_merkle_proof_verify.sv -----
// A hashed node is accepted, hashed as three SHA-256 blocks of 64 rounds on a
// round-per-cycle core and finished before the next node is accepted; the last
// node of a proof also passes the result state. A first node is not hashed,
// and a one-node proof goes straight to the result state. The result item is
// held in an output register, so beyond the hash the input only stalls when a
// new result is ready while the previous one is still waiting.
// ----------------------------------------------------------------------------
// salted_merkle_proof_verify
// Top level of the salted Merkle authentication path checker.
// ----------------------------------------------------------------------------
module salted_merkle_proof_verify #(
  parameter int unsigned MAX_PROOF_NODES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smpv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [smpv_pkg::CfgDataW-1:0] cfg_data_i,
  smpv_if.sink                          node_in,
  smpv_if.source                        result_out
);
  import smpv_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  smpv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (node_in.valid),
    .in_ready_o  (node_in.ready),
    .out_valid_o (result_out.valid),
    .out_ready_i (result_out.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  smpv_datapath #(.MaxProofNodes(MAX_PROOF_NODES)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (node_in.payload),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (result_out.payload)
  );

endmodule

// ----- rtl/smpv_checker.sv -----
// ----------------------------------------------------------------------------
// smpv_checker
// Port-level checks of the verifier, bound to the top level.
// ----------------------------------------------------------------------------
module smpv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic passed,
  input logic [5:0] count
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(count) && $stable(passed))
    else $error("result dropped or changed");
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> count != 6'd0) else $error("zero node count");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("item accepted back to back");
endmodule

bind salted_merkle_proof_verify smpv_checker u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (node_in.valid),
  .in_ready  (node_in.ready),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .passed    (result_out.payload.proof_passed),
  .count     (result_out.payload.nodes_in_proof)
);
